/* hdl/trv_pkg.sv */
package trv_pkg;

   localparam int HistoryDepthDefault = 32;
   localparam int CoordWidth = 32;
   localparam int ArmWidth = 26;
   localparam int SegIndexWidth = 5;
   localparam int CsrIndexWidth = 3;
   localparam logic [23:0] HalfWidthReset = 24'd6554;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_HALF_WIDTH = 3'd0,
      CSR_CAMERA_X   = 3'd1,
      CSR_CAMERA_Y   = 3'd2,
      CSR_CAMERA_Z   = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic signed [CoordWidth:0] x;
      logic signed [CoordWidth:0] y;
      logic signed [CoordWidth:0] z;
   } line_type;

   typedef struct packed {
      logic signed [CoordWidth-1:0] x;
      logic signed [CoordWidth-1:0] y;
      logic signed [CoordWidth-1:0] z;
   } point_type;

   typedef struct packed {
      logic signed [ArmWidth-1:0] x;
      logic signed [ArmWidth-1:0] y;
      logic signed [ArmWidth-1:0] z;
   } arm_type;

endpackage

/* hdl/trail_ribbon_vertex_generator.sv */
// An accepted item starts a walk over the stored segments; each segment reads the history,
// forms six cross products and normalizes them, and, unless the arm is zero, takes a 32-step
// square root and three divisions before its two vertices are emitted, each held until taken.
// A new item is taken only in the idle state, so not before every segment of the last one is out.
// Reset clears the entry count, head, segment index and state machines, and loads the CSRs' reset values.
module trail_ribbon_vertex_generator import trv_pkg::*; #(
   parameter int HISTORY_DEPTH = HistoryDepthDefault
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [CsrIndexWidth-1:0]      csr_index,
   input  logic [31:0]                   csr_write_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [CoordWidth-1:0]  req_point_x,
   input  logic signed [CoordWidth-1:0]  req_point_y,
   input  logic signed [CoordWidth-1:0]  req_point_z,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [CoordWidth-1:0]  rsp_vertex_x,
   output logic signed [CoordWidth-1:0]  rsp_vertex_y,
   output logic signed [CoordWidth-1:0]  rsp_vertex_z,
   output logic [SegIndexWidth-1:0]      rsp_segment_index,
   output logic                          rsp_side,
   output logic                          rsp_last
);

   localparam int PtrW = $clog2(HISTORY_DEPTH);
   localparam int CntW = $clog2(HISTORY_DEPTH + 1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_READ  = 6'b000010,
      S_LOAD  = 6'b000100,
      S_ARM   = 6'b001000,
      S_EMIT0 = 6'b010000,
      S_EMIT1 = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [PtrW-1:0] head_ff;
   logic [CntW-1:0] count_ff;
   logic [PtrW-1:0] seg_ff;
   logic [23:0] half_width_ff;
   point_type camera_ff;
   point_type cur_ff;
   point_type nxt_ff;

   logic accept;
   logic [PtrW-1:0] head_new;
   logic [PtrW:0] rd_sum;
   logic [PtrW-1:0] rd_addr;
   logic [3*CoordWidth-1:0] rd_data;
   logic is_last;
   logic arm_start;
   logic arm_done;
   line_type line;
   arm_type arm;

   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign head_new = (head_ff == '0) ? PtrW'(HISTORY_DEPTH - 1) : head_ff - 1'b1;
   assign rd_sum = {1'b0, head_ff} + {1'b0, seg_ff} + 1'b1;
   assign rd_addr = (rd_sum >= (PtrW + 1)'(HISTORY_DEPTH))
                    ? PtrW'(rd_sum - (PtrW + 1)'(HISTORY_DEPTH)) : rd_sum[PtrW-1:0];
   assign is_last = (CntW'(seg_ff) + CntW'(2)) == count_ff;
   assign arm_start = (state_ff == S_LOAD);

   assign line.x = 33'(nxt_ff.x) - 33'(cur_ff.x);
   assign line.y = 33'(nxt_ff.y) - 33'(cur_ff.y);
   assign line.z = 33'(nxt_ff.z) - 33'(cur_ff.z);

   trv_ram #(
      .WIDTH(3 * CoordWidth),
      .DEPTH(HISTORY_DEPTH)
   ) u_history (
      .clock  (clock),
      .wr_en  (accept),
      .wr_addr(head_new),
      .wr_data({req_point_x, req_point_y, req_point_z}),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   trv_arm u_arm (
      .clock     (clock),
      .reset     (reset),
      .start     (arm_start),
      .line      (line),
      .camera    (camera_ff),
      .half_width(half_width_ff),
      .done      (arm_done),
      .arm       (arm)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && count_ff != '0) begin
               state_in = S_READ;
            end
         end
         S_READ: state_in = S_LOAD;
         S_LOAD: state_in = S_ARM;
         S_ARM: begin
            if (arm_done) begin
               state_in = S_EMIT0;
            end
         end
         S_EMIT0: begin
            if (rsp_ready) begin
               state_in = S_EMIT1;
            end
         end
         S_EMIT1: begin
            if (rsp_ready) begin
               state_in = is_last ? S_IDLE : S_READ;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= '0;
         count_ff <= '0;
         seg_ff <= '0;
         half_width_ff <= HalfWidthReset;
         camera_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_HALF_WIDTH: half_width_ff <= csr_write_data[23:0];
               CSR_CAMERA_X: camera_ff.x <= csr_write_data;
               CSR_CAMERA_Y: camera_ff.y <= csr_write_data;
               CSR_CAMERA_Z: camera_ff.z <= csr_write_data;
               default: begin
               end
            endcase
         end
         if (accept) begin
            head_ff <= head_new;
            seg_ff <= '0;
            if (count_ff != CntW'(HISTORY_DEPTH)) begin
               count_ff <= count_ff + 1'b1;
            end
         end
         if (state_ff == S_EMIT1 && rsp_ready) begin
            seg_ff <= seg_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_ff <= {req_point_x, req_point_y, req_point_z};
      end else if (state_ff == S_EMIT1 && rsp_ready) begin
         cur_ff <= nxt_ff;
      end
      if (state_ff == S_LOAD) begin
         nxt_ff <= rd_data;
      end
   end

   function automatic logic signed [CoordWidth-1:0] sat_add(
      input logic signed [CoordWidth-1:0] p,
      input logic signed [ArmWidth-1:0] a,
      input logic sub
   );
      logic signed [CoordWidth+1:0] s;
      s = sub ? (34'(p) - 34'(a)) : (34'(p) + 34'(a));
      if (s > 34'sh07FFFFFFF) begin
         return 32'h7FFFFFFF;
      end else if (s < -34'sh080000000) begin
         return 32'h80000000;
      end
      return s[CoordWidth-1:0];
   endfunction

   assign rsp_valid = (state_ff == S_EMIT0) || (state_ff == S_EMIT1);
   assign rsp_side = (state_ff == S_EMIT1);
   assign rsp_last = rsp_side && is_last;
   assign rsp_segment_index = SegIndexWidth'(seg_ff);
   assign rsp_vertex_x = sat_add(cur_ff.x, arm.x, rsp_side);
   assign rsp_vertex_y = sat_add(cur_ff.y, arm.y, rsp_side);
   assign rsp_vertex_z = sat_add(cur_ff.z, arm.z, rsp_side);

endmodule

/* hdl/trv_ram.sv */
module trv_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* hdl/trv_arm.sv */
module trv_arm import trv_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  line_type                     line,
   input  point_type                    camera,
   input  logic [23:0]                  half_width,
   output logic                         done,
   output arm_type                      arm
);

   typedef enum logic [8:0] {
      A_IDLE  = 9'b000000001,
      A_MUL   = 9'b000000010,
      A_CROSS = 9'b000000100,
      A_NORM  = 9'b000001000,
      A_SQ    = 9'b000010000,
      A_ROOT  = 9'b000100000,
      A_DMUL  = 9'b001000000,
      A_DLOAD = 9'b010000000,
      A_DIV   = 9'b100000000
   } arm_state_type;

   arm_state_type state_ff, state_in;
   logic [2:0] k_ff, k_in;
   logic [4:0] j_ff, j_in;
   logic signed [64:0] prod_ff [6];
   logic [63:0] mag_ff [3];
   logic [2:0] neg_ff;
   logic [61:0] sq_ff;
   logic [63:0] s_ff;
   logic [63:0] res_ff;
   logic [63:0] bit_ff;
   logic [54:0] num_ff;
   logic [31:0] rem_ff;
   logic [24:0] nlo_ff;
   logic [24:0] q_ff;
   logic signed [ArmWidth-1:0] arm_ff [3];
   logic done_ff;

   logic signed [32:0] op_a;
   logic signed [31:0] op_b;
   logic signed [64:0] prod;
   logic signed [64:0] diff [3];
   logic [63:0] orv;
   logic [63:0] trial;
   logic [55:0] num_round;
   logic [32:0] div_t;
   logic div_ge;
   logic [24:0] q_new;
   logic [30:0] mag_lo;

   always_comb begin
      case (k_ff)
         3'd0: begin op_a = line.y; op_b = camera.z; end
         3'd1: begin op_a = line.z; op_b = camera.y; end
         3'd2: begin op_a = line.z; op_b = camera.x; end
         3'd3: begin op_a = line.x; op_b = camera.z; end
         3'd4: begin op_a = line.x; op_b = camera.y; end
         default: begin op_a = line.y; op_b = camera.x; end
      endcase
   end

   assign prod = op_a * op_b;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         diff[c] = (prod_ff[2*c] >>> 1) - (prod_ff[2*c+1] >>> 1);
      end
   end

   assign orv = mag_ff[0] | mag_ff[1] | mag_ff[2];
   assign trial = res_ff + bit_ff;
   assign mag_lo = mag_ff[k_ff[1:0]][30:0];
   assign num_round = {1'b0, num_ff} + {24'd0, res_ff[32:1]};
   assign div_t = {rem_ff, nlo_ff[j_ff]};
   assign div_ge = div_t >= res_ff[32:0];
   always_comb begin
      q_new = q_ff;
      q_new[j_ff] = div_ge;
   end

   always_comb begin
      state_in = state_ff;
      k_in = k_ff;
      j_in = j_ff;
      case (state_ff)
         A_IDLE: begin
            if (start) begin
               state_in = A_MUL;
               k_in = 3'd0;
            end
         end
         A_MUL: begin
            k_in = k_ff + 3'd1;
            if (k_ff == 3'd5) begin
               state_in = A_CROSS;
            end
         end
         A_CROSS: state_in = A_NORM;
         A_NORM: begin
            if (orv == 64'd0) begin
               state_in = A_IDLE;
            end else if (orv[63:31] == 33'd0 && orv[30]) begin
               state_in = A_SQ;
               k_in = 3'd0;
            end
         end
         A_SQ: begin
            k_in = k_ff + 3'd1;
            if (k_ff == 3'd3) begin
               state_in = A_ROOT;
            end
         end
         A_ROOT: begin
            if (bit_ff[0]) begin
               state_in = A_DMUL;
               k_in = 3'd0;
            end
         end
         A_DMUL: state_in = A_DLOAD;
         A_DLOAD: begin
            state_in = A_DIV;
            j_in = 5'd24;
         end
         A_DIV: begin
            j_in = j_ff - 5'd1;
            if (j_ff == 5'd0) begin
               k_in = k_ff + 3'd1;
               state_in = (k_ff == 3'd2) ? A_IDLE : A_DMUL;
            end
         end
         default: state_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= A_IDLE;
         k_ff <= 3'd0;
         j_ff <= 5'd0;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff <= k_in;
         j_ff <= j_in;
         done_ff <= (state_ff == A_NORM && orv == 64'd0) ||
                    (state_ff == A_DIV && j_ff == 5'd0 && k_ff == 3'd2);
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         A_MUL: prod_ff[k_ff] <= prod;
         A_CROSS: begin
            for (int c = 0; c < 3; c++) begin
               neg_ff[c] <= diff[c][64];
               mag_ff[c] <= diff[c][64] ? 64'(-diff[c]) : diff[c][63:0];
            end
         end
         A_NORM: begin
            if (orv == 64'd0) begin
               for (int c = 0; c < 3; c++) begin
                  arm_ff[c] <= '0;
               end
            end else if (orv[63:31] != 33'd0) begin
               for (int c = 0; c < 3; c++) begin
                  mag_ff[c] <= mag_ff[c] >> 1;
               end
            end else if (!orv[30]) begin
               for (int c = 0; c < 3; c++) begin
                  mag_ff[c] <= mag_ff[c] << 1;
               end
            end
            s_ff <= 64'd0;
         end
         A_SQ: begin
            if (k_ff != 3'd3) begin
               sq_ff <= mag_lo * mag_lo;
            end
            if (k_ff != 3'd0) begin
               s_ff <= s_ff + {2'b00, sq_ff};
            end
            res_ff <= 64'd0;
            bit_ff <= 64'd1 << 62;
         end
         A_ROOT: begin
            if (s_ff >= trial) begin
               s_ff <= s_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         A_DMUL: num_ff <= mag_lo * half_width;
         A_DLOAD: begin
            rem_ff <= {1'b0, num_round[55:25]};
            nlo_ff <= num_round[24:0];
            q_ff <= 25'd0;
         end
         A_DIV: begin
            rem_ff <= div_ge ? 32'(div_t - res_ff[32:0]) : div_t[31:0];
            q_ff <= q_new;
            if (j_ff == 5'd0) begin
               arm_ff[k_ff[1:0]] <= neg_ff[k_ff[1:0]] ? -$signed({1'b0, q_new})
                                                     : $signed({1'b0, q_new});
            end
         end
         default: begin
         end
      endcase
   end

   assign done = done_ff;
   assign arm.x = arm_ff[0];
   assign arm.y = arm_ff[1];
   assign arm.z = arm_ff[2];

endmodule
